### src/mi3_pkg.sv
package mi3_pkg;

	// one matrix, row-major, signed Q16.16
	typedef struct packed {
		logic signed [31:0] in_r0c0;
		logic signed [31:0] in_r0c1;
		logic signed [31:0] in_r0c2;
		logic signed [31:0] in_r1c0;
		logic signed [31:0] in_r1c1;
		logic signed [31:0] in_r1c2;
		logic signed [31:0] in_r2c0;
		logic signed [31:0] in_r2c1;
		logic signed [31:0] in_r2c2;
	} mat_in_t;

	// inverse, saturated Q16.16, plus singular flag
	typedef struct packed {
		logic signed [31:0] out_r0c0;
		logic signed [31:0] out_r0c1;
		logic signed [31:0] out_r0c2;
		logic signed [31:0] out_r1c0;
		logic signed [31:0] out_r1c1;
		logic signed [31:0] out_r1c2;
		logic signed [31:0] out_r2c0;
		logic signed [31:0] out_r2c1;
		logic signed [31:0] out_r2c2;
		logic               singular;
	} mat_out_t;

	localparam int NENT  = 9;
	localparam int EW    = 32;  // entry width
	localparam int PW    = 64;  // 2x2 product width
	localparam int CW    = 65;  // cofactor width
	localparam int DW    = 99;  // determinant width, signed
	localparam int AW    = 98;  // determinant magnitude width
	localparam int NSTEP = 33;  // quotient bits produced by the divider

	typedef logic signed [EW-1:0] ent_t;
	typedef logic signed [CW-1:0] cof_t;
	typedef logic signed [DW-1:0] det_t;

	// cofactor k = m[A]*m[B] - m[C]*m[D], k = row*3 + col of the cofactor matrix
	localparam int CF_A [NENT] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
	localparam int CF_B [NENT] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
	localparam int CF_C [NENT] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
	localparam int CF_D [NENT] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

### src/mi3_cofactor.sv
module mi3_cofactor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  mi3_pkg::ent_t     m [mi3_pkg::NENT],
	output logic              valid_s2,
	output mi3_pkg::cof_t     cof_s2 [mi3_pkg::NENT],
	output mi3_pkg::ent_t     row0_s2 [3]
);
	import mi3_pkg::*;

	logic                 valid_s1;
	logic signed [PW-1:0] pa_s1 [NENT];
	logic signed [PW-1:0] pb_s1 [NENT];
	ent_t                 row0_s1 [3];

	// stage 1: the eighteen 2x2 products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NENT; k++) begin
				pa_s1[k] <= m[CF_A[k]] * m[CF_B[k]];
				pb_s1[k] <= m[CF_C[k]] * m[CF_D[k]];
			end
			for (int k = 0; k < 3; k++) begin
				row0_s1[k] <= m[k];
			end
		end
	end

	// stage 2: exact differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NENT; k++) begin
				cof_s2[k] <= {pa_s1[k][PW-1], pa_s1[k]} - {pb_s1[k][PW-1], pb_s1[k]};
			end
			row0_s2 <= row0_s1;
		end
	end

endmodule

### src/mi3_det.sv
module mi3_det (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  mi3_pkg::cof_t     cof [mi3_pkg::NENT],
	input  mi3_pkg::ent_t     row0 [3],
	output logic              valid_s5,
	output mi3_pkg::cof_t     cof_s5 [mi3_pkg::NENT],
	output mi3_pkg::det_t     det_s5
);
	import mi3_pkg::*;

	logic                 valid_s3, valid_s4;
	logic signed [65:0]   lo_s3 [3];
	logic signed [63:0]   hi_s3 [3];
	det_t                 term_s4 [3];
	cof_t                 cof_s3 [NENT];
	cof_t                 cof_s4 [NENT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 3: cofactor split in two halves, each times a row-0 entry
			for (int k = 0; k < 3; k++) begin
				lo_s3[k] <= $signed({1'b0, cof[k][32:0]}) * row0[k];
				hi_s3[k] <= $signed(cof[k][64:33]) * row0[k];
			end
			cof_s3 <= cof;
			// stage 4: recombine the halves
			for (int k = 0; k < 3; k++) begin
				term_s4[k] <= {{2{hi_s3[k][63]}}, hi_s3[k], 33'b0}
					+ {{33{lo_s3[k][65]}}, lo_s3[k]};
			end
			cof_s4 <= cof_s3;
			// stage 5: expansion along row 0
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
		end
	end

endmodule

### src/mi3_divider.sv
module mi3_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  mi3_pkg::cof_t     cof [mi3_pkg::NENT],
	input  mi3_pkg::det_t     det,
	output logic              valid_o,
	output mi3_pkg::mat_out_t res_o
);
	import mi3_pkg::*;

	// sign and magnitude stage
	logic            valid_a_s, sing_a_s;
	logic [AW-1:0]   dabs_a_s;
	logic [63:0]     nabs_a_s [NENT];
	logic            neg_a_s [NENT];

	// remainder, quotient and side data per divider step
	logic            valid_s [NSTEP+1];
	logic            sing_s [NSTEP+1];
	logic [AW-1:0]   dabs_s [NSTEP+1];
	logic [DW-1:0]   rem_s [NSTEP+1][NENT];
	logic [NSTEP-1:0] quo_s [NSTEP+1][NENT];
	logic            ovf_s [NSTEP+1][NENT];
	logic            neg_s [NSTEP+1][NENT];
	logic            lsb_s [NSTEP+1][NENT];

	logic [31:0]     res [NENT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_a_s <= 1'b0;
		end else if (en) begin
			valid_a_s <= in_valid;
		end
	end

	// adjugate entry for output i*3+j is cofactor j*3+i
	always_ff @(posedge clk) begin
		if (en) begin
			sing_a_s <= (det == '0);
			dabs_a_s <= det[DW-1] ? AW'(-det) : det[AW-1:0];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					nabs_a_s[i*3+j] <= cof[j*3+i][CW-1] ? 64'(-cof[j*3+i])
						: cof[j*3+i][63:0];
					neg_a_s[i*3+j]  <= cof[j*3+i][CW-1] ^ det[DW-1];
				end
			end
		end
	end

	// overflow check and remainder seed: quotient fits 33 bits iff |adj| < 2|det|
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= valid_a_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_s[0] <= sing_a_s;
			dabs_s[0] <= dabs_a_s;
			for (int k = 0; k < NENT; k++) begin
				ovf_s[0][k] <= {35'b0, nabs_a_s[k]} >= {dabs_a_s, 1'b0};
				rem_s[0][k] <= {36'b0, nabs_a_s[k][63:1]};
				lsb_s[0][k] <= nabs_a_s[k][0];
				neg_s[0][k] <= neg_a_s[k];
				quo_s[0][k] <= '0;
			end
		end
	end

	// one restoring step per stage
	for (genvar g = 0; g < NSTEP; g++) begin : g_step
		logic [DW:0] trial [NENT];

		always_comb begin
			for (int k = 0; k < NENT; k++) begin
				trial[k] = {rem_s[g][k], (g == 0) ? lsb_s[g][k] : 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sing_s[g+1] <= sing_s[g];
				dabs_s[g+1] <= dabs_s[g];
				for (int k = 0; k < NENT; k++) begin
					if (trial[k] >= {2'b0, dabs_s[g]}) begin
						rem_s[g+1][k] <= DW'(trial[k] - {2'b0, dabs_s[g]});
						quo_s[g+1][k] <= {quo_s[g][k][NSTEP-2:0], 1'b1};
					end else begin
						rem_s[g+1][k] <= trial[k][DW-1:0];
						quo_s[g+1][k] <= {quo_s[g][k][NSTEP-2:0], 1'b0};
					end
					ovf_s[g+1][k] <= ovf_s[g][k];
					neg_s[g+1][k] <= neg_s[g][k];
					lsb_s[g+1][k] <= lsb_s[g][k];
				end
			end
		end
	end

	// saturate, apply sign, force zero when singular
	always_comb begin
		for (int k = 0; k < NENT; k++) begin
			if (sing_s[NSTEP]) begin
				res[k] = '0;
			end else if (ovf_s[NSTEP][k]
				|| quo_s[NSTEP][k] > {1'b0, (neg_s[NSTEP][k] ? SAT_NEG : SAT_POS)}) begin
				res[k] = neg_s[NSTEP][k] ? SAT_NEG : SAT_POS;
			end else if (neg_s[NSTEP][k]) begin
				res[k] = 32'(-quo_s[NSTEP][k]);
			end else begin
				res[k] = quo_s[NSTEP][k][31:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_o <= {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8],
				sing_s[NSTEP]};
		end
	end

endmodule

### src/matrix3x3_inverse_core.sv
// 3x3 matrix inverse in signed Q16.16, adjugate over exact determinant.
// input channel: in_valid / in_ready carry one matrix (in_data, row-major).
// output channel: out_valid / out_ready carry the inverse (out_data), each
// entry truncated toward zero and saturated to 32 bits, plus a singular flag;
// a matrix whose determinant is exactly zero gives singular = 1 and zeros.
// depth: 41 register stages (2 cofactor stages, 3 determinant stages,
// 2 divider setup stages, 33 divider steps, 1 output register).
// throughput: one matrix per cycle while out_ready does not stall the pipeline;
// the 33-stage restoring divider, nine lanes wide, sets the depth.
// the whole pipeline advances together: when out_valid is high and
// out_ready low, every stage holds and in_ready drops in the same cycle,
// so nothing is lost or repeated. bubbles inside the pipeline are not
// squeezed out while it stalls.
// reset clears all valid bits; the pipeline then accepts immediately.
module matrix3x3_inverse_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mi3_pkg::mat_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mi3_pkg::mat_out_t out_data
);
	import mi3_pkg::*;

	logic en;
	ent_t m [NENT];
	logic valid_s2, valid_s5;
	cof_t cof_s2 [NENT];
	cof_t cof_s5 [NENT];
	ent_t row0_s2 [3];
	det_t det_s5;

	// global advance
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign m = '{in_data.in_r0c0, in_data.in_r0c1, in_data.in_r0c2,
		in_data.in_r1c0, in_data.in_r1c1, in_data.in_r1c2,
		in_data.in_r2c0, in_data.in_r2c1, in_data.in_r2c2};

	mi3_cofactor u_cof (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.m        (m),
		.valid_s2 (valid_s2),
		.cof_s2   (cof_s2),
		.row0_s2  (row0_s2)
	);

	mi3_det u_det (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s2),
		.cof      (cof_s2),
		.row0     (row0_s2),
		.valid_s5 (valid_s5),
		.cof_s5   (cof_s5),
		.det_s5   (det_s5)
	);

	mi3_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s5),
		.cof      (cof_s5),
		.det      (det_s5),
		.valid_o  (out_valid),
		.res_o    (out_data)
	);

`ifndef NO_ASSERTIONS
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |-> out_data.out_r0c0 == 0 && out_data.out_r1c1 == 0
			&& out_data.out_r2c2 == 0 && out_data.out_r0c2 == 0 && out_data.out_r2c0 == 0)
		else $error("singular item with nonzero entries");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("pipeline moved under stall");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("intake not tied to pipeline advance");
`endif

endmodule

### bench/inverse_checker.sv
module inverse_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  mi3_pkg::mat_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  mi3_pkg::mat_out_t out_data,
	output int                fail_count,
	output int                pending,
	output int                singular_seen,
	output int                sat_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import mi3_pkg::*;

	mat_out_t expected_inverses[$];

	// truncated, saturated quotient of adj * 2^32 by det
	function automatic logic [31:0] scaled_quotient(logic signed [127:0] adj,
			logic signed [127:0] det);
		logic [127:0] num_mag;
		logic [127:0] den_mag;
		logic [127:0] quo;
		logic         neg;
		neg = (adj < 0) != (det < 0);
		num_mag = (adj < 0) ? -adj : adj;
		den_mag = (det < 0) ? -det : det;
		quo = (num_mag << 32) / den_mag;
		if (!neg && quo > 128'h7FFF_FFFF)
			return SAT_POS;
		if (neg && quo > 128'h8000_0000)
			return SAT_NEG;
		return neg ? -quo[31:0] : quo[31:0];
	endfunction

	// adjugate over determinant for one matrix
	function automatic mat_out_t predict_inverse(mat_in_t mat);
		logic signed [127:0] m[9];
		logic signed [127:0] cof[9];
		logic signed [127:0] det;
		logic [31:0]         ent[9];
		mat_out_t            res;
		m = '{mat.in_r0c0, mat.in_r0c1, mat.in_r0c2, mat.in_r1c0, mat.in_r1c1,
			mat.in_r1c2, mat.in_r2c0, mat.in_r2c1, mat.in_r2c2};
		cof[0] = m[4] * m[8] - m[5] * m[7];
		cof[1] = m[5] * m[6] - m[3] * m[8];
		cof[2] = m[3] * m[7] - m[4] * m[6];
		cof[3] = m[2] * m[7] - m[1] * m[8];
		cof[4] = m[0] * m[8] - m[2] * m[6];
		cof[5] = m[1] * m[6] - m[0] * m[7];
		cof[6] = m[1] * m[5] - m[2] * m[4];
		cof[7] = m[2] * m[3] - m[0] * m[5];
		cof[8] = m[0] * m[4] - m[1] * m[3];
		det = cof[0] * m[0] + cof[1] * m[1] + cof[2] * m[2];
		res = '0;
		if (det == 0) begin
			res.singular = 1'b1;
			return res;
		end
		// transpose: entry (i,j) takes cofactor (j,i)
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				ent[i * 3 + j] = scaled_quotient(cof[j * 3 + i], det);
		res = {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7],
			ent[8], 1'b0};
		return res;
	endfunction

	function automatic void compare_entry(string name, logic [31:0] exp_v,
			logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		singular_seen = 0;
		sat_seen = 0;
	end

	// record accepted matrices and compare accepted results
	always @(posedge clk) begin
		mat_out_t exp_r;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_inverses.push_back(predict_inverse(in_data));
			if (out_valid && out_ready) begin
				if (expected_inverses.size() == 0) begin
					$error("result with no matrix outstanding");
					fail_count++;
				end else begin
					exp_r = expected_inverses.pop_front();
					if (exp_r.singular)
						singular_seen++;
					if (out_data.out_r0c0 == SAT_POS || out_data.out_r0c0 == SAT_NEG)
						sat_seen++;
					compare_entry("out_r0c0", exp_r.out_r0c0, out_data.out_r0c0);
					compare_entry("out_r0c1", exp_r.out_r0c1, out_data.out_r0c1);
					compare_entry("out_r0c2", exp_r.out_r0c2, out_data.out_r0c2);
					compare_entry("out_r1c0", exp_r.out_r1c0, out_data.out_r1c0);
					compare_entry("out_r1c1", exp_r.out_r1c1, out_data.out_r1c1);
					compare_entry("out_r1c2", exp_r.out_r1c2, out_data.out_r1c2);
					compare_entry("out_r2c0", exp_r.out_r2c0, out_data.out_r2c0);
					compare_entry("out_r2c1", exp_r.out_r2c1, out_data.out_r2c1);
					compare_entry("out_r2c2", exp_r.out_r2c2, out_data.out_r2c2);
					if (exp_r.singular !== out_data.singular) begin
						$error("singular mismatch: expected %b, got %b", exp_r.singular,
							out_data.singular);
						fail_count++;
					end
				end
			end
			pending = expected_inverses.size();
		end
	end
endmodule

### bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mi3_pkg::*;

	localparam int RAND_ITEMS = 1800;
	localparam int IDLE_LIMIT = 5000;
	localparam logic [31:0] Q1 = 32'h0001_0000;
	localparam logic [31:0] QM1 = 32'hFFFF_0000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	mat_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	mat_out_t out_data;
	int       fail_count;
	int       pending;
	int       singular_seen;
	int       sat_seen;
	int       idle_cycles;
	int       sent;
	bit       long_hold_req;
	bit       long_hold_done;
	bit       stimulus_done;

	matrix3x3_inverse_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	inverse_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.singular_seen(singular_seen),
		.sat_seen     (sat_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// mostly short gaps, a few long ones, often none
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// entry of assorted magnitude
	function automatic logic [31:0] pick_entry();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return {{16{1'b0}}, 16'($urandom)};
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
			4: return 32'($signed(13'($urandom)));
			default: return 32'($signed(20'($urandom)));
		endcase
	endfunction

	function automatic mat_in_t random_matrix();
		logic [31:0] e[9];
		int          kind;
		foreach (e[i])
			e[i] = pick_entry();
		kind = $urandom_range(0, 9);
		// rank-deficient: copy or negate a row, or zero a column
		if (kind == 0) begin
			e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
		end else if (kind == 1) begin
			e[3] = -e[0]; e[4] = -e[1]; e[5] = -e[2];
		end else if (kind == 2) begin
			e[1] = 0; e[4] = 0; e[7] = 0;
		end
		return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
	endfunction

	// present one matrix and hold it until accepted
	task automatic send_matrix(mat_in_t mat);
		in_valid <= 1'b1;
		in_data  <= mat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		int hold;
		out_ready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold_done = 1'b1;
			end
			hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		mat_in_t one;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		idle_cycles = 0;
		sent = 0;
		long_hold_req = 1'b0;
		stimulus_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, negated identity, zero, extremes, tiny and huge
		send_matrix({Q1, 32'd0, 32'd0, 32'd0, Q1, 32'd0, 32'd0, 32'd0, Q1});
		send_matrix({QM1, 32'd0, 32'd0, 32'd0, QM1, 32'd0, 32'd0, 32'd0, QM1});
		send_matrix('0);
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix({9{32'h8000_0000}});
		send_matrix({32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'd0,
			32'd0, 32'd0, 32'h8000_0000});
		send_matrix({32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0,
			32'd0, 32'd0, 32'h7FFF_FFFF});
		send_matrix({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
		send_matrix({32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0,
			32'd0, 32'd1});
		send_matrix({32'd0, Q1, 32'd0, 32'd0, 32'd0, Q1, Q1, 32'd0, 32'd0});
		send_matrix({Q1, Q1, Q1, Q1, Q1, Q1, Q1, Q1, Q1});
		send_matrix({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
		send_matrix({32'h0002_0000, 32'd0, 32'd0, 32'd0, 32'h0000_8000, 32'd0, 32'd0,
			32'd0, 32'h7FFF_FFFF});
		send_matrix({32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0,
			32'd0, 32'h8000_0000});

		// sender pause until all results are back
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);

		// long receiver hold-off while the sender keeps offering
		long_hold_req = 1'b1;
		while (!long_hold_done) begin
			one = random_matrix();
			send_matrix(one);
		end

		// random part
		for (int n = 0; n < RAND_ITEMS; n++) begin
			one = random_matrix();
			send_matrix(one);
			if (n % 300 > 200)
				send_gap(pick_gap());
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d matrices checked, %0d singular, %0d with saturated first entry",
			sent, singular_seen, sat_seen);
		$display("covered directed extremes, long output stall and random stalls");
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### matrix3x3_inverse_core.f
src/mi3_pkg.sv
src/mi3_cofactor.sv
src/mi3_det.sv
src/mi3_divider.sv
src/matrix3x3_inverse_core.sv
bench/inverse_checker.sv
bench/testbench.sv
